// ===== design/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg: shared types for the bitmap free-slot allocator
// Request and result payloads and the operation codes.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int SLOT_W  = 12;
    localparam int TOTAL_W = 13;

    localparam logic [1:0] OP_FIND    = 2'd0;
    localparam logic [1:0] OP_OCCUPY  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot_index;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  free_slot;
        logic               found;
        logic [TOTAL_W-1:0] free_total;
    } out_t;

endpackage

// ===== design/bitmap_free_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_free_slot_allocator: find, occupy and release slots in a bitmap
// One bitmap word is read from the internal memory per cycle and checked by a
// single shared word unit (range compare, lowest-zero search, bit update).
// ----------------------------------------------------------------------------
// A request is taken only in the idle state. It goes to the scan state,
// which reads words from word 0 on until one hits (a find on a full map or
// an out-of-range slot reads every word), or straight to the done state for
// an unused op code. No new request is taken until the done state has put
// the result in the output register; a held result stalls it. After reset a
// clearing pass zeroes the bitmap; in_ready stays low until it ends.
// ----------------------------------------------------------------------------
module bitmap_free_slot_allocator #(
    parameter int MAP_WORDS = 128,
    parameter int WORD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bfsa_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output bfsa_pkg::out_t out_data
);
    import bfsa_pkg::*;

    localparam int TOTAL = MAP_WORDS * WORD_BITS;
    localparam int TOT_W = $clog2(TOTAL + 1);
    localparam int CW    = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;
    localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W = $clog2(MAP_WORDS + 1);
    localparam int BIT_W = $clog2(WORD_BITS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic [TOT_W-1:0]     issue_base_reg, issue_base_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [TOT_W-1:0]     rd_base_reg, rd_base_next;
    logic [TOT_W-1:0]     free_cnt_reg, free_cnt_next;
    in_t                  req_reg, req_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic                 res_found_reg, res_found_next;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_data_reg, out_data_next;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] mem_rdata_reg;
    logic                 mem_re, mem_we;
    logic [IDX_W-1:0]     mem_raddr, mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // shared word unit
    logic [WORD_BITS-1:0] inv_word, low_zero;
    logic [BIT_W-1:0]     zero_pos;
    logic [CW-1:0]        base_ext, slot_ext, hit_slot;
    logic                 in_word, word_free, hit;
    logic [BIT_W-1:0]     bit_pos;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 bit_used;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        inv_word  = ~mem_rdata_reg;
        low_zero  = inv_word & (~inv_word + WORD_BITS'(1));
        zero_pos  = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (low_zero[i])
            begin
                zero_pos = zero_pos | BIT_W'(i);
            end
        end
        word_free = (mem_rdata_reg != {WORD_BITS{1'b1}});
        base_ext  = CW'(rd_base_reg);
        slot_ext  = CW'(req_reg.slot_index);
        in_word   = (slot_ext >= base_ext) && (slot_ext < base_ext + CW'(WORD_BITS));
        bit_pos   = BIT_W'(slot_ext - base_ext);
        bit_mask  = WORD_BITS'(1) << bit_pos;
        bit_used  = |(mem_rdata_reg & bit_mask);
        hit_slot  = base_ext + CW'(zero_pos);
        hit       = rd_vld_reg && ((req_reg.op == OP_FIND) ? word_free : in_word);
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        issue_base_next = issue_base_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        rd_base_next    = rd_base_reg;
        free_cnt_next   = free_cnt_reg;
        req_next        = req_reg;
        res_slot_next   = res_slot_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = issue_cnt_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = mem_rdata_reg;
        in_ready        = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = issue_cnt_reg[IDX_W-1:0];
                mem_wdata      = '0;
                issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                if (issue_cnt_reg == CNT_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = in_data;
                    res_slot_next   = '0;
                    res_found_next  = 1'b0;
                    issue_cnt_next  = '0;
                    issue_base_next = '0;
                    if (in_data.op == OP_FIND || in_data.op == OP_OCCUPY ||
                        in_data.op == OP_RELEASE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_DONE;
                    if (req_reg.op == OP_FIND)
                    begin
                        res_slot_next  = hit_slot[SLOT_W-1:0];
                        res_found_next = 1'b1;
                    end
                    else if (req_reg.op == OP_OCCUPY)
                    begin
                        if (!bit_used)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata_reg | bit_mask;
                            if (free_cnt_reg != '0)
                            begin
                                free_cnt_next = free_cnt_reg - TOT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        if (bit_used)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata_reg & ~bit_mask;
                            if (free_cnt_reg < TOT_W'(TOTAL))
                            begin
                                free_cnt_next = free_cnt_reg + TOT_W'(1);
                            end
                        end
                    end
                end
                else if (issue_cnt_reg != CNT_W'(MAP_WORDS))
                begin
                    // advance the read one word ahead of the check
                    mem_re          = 1'b1;
                    rd_vld_next     = 1'b1;
                    rd_idx_next     = issue_cnt_reg[IDX_W-1:0];
                    rd_base_next    = issue_base_reg;
                    issue_cnt_next  = issue_cnt_reg + CNT_W'(1);
                    issue_base_next = issue_base_reg + TOT_W'(WORD_BITS);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.free_slot  = res_slot_reg;
                    out_data_next.found      = res_found_reg;
                    out_data_next.free_total = TOTAL_W'(CW'(free_cnt_reg));
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            issue_cnt_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            free_cnt_reg   <= TOT_W'(TOTAL);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            free_cnt_reg   <= free_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_base_reg <= issue_base_next;
        rd_idx_reg     <= rd_idx_next;
        rd_base_reg    <= rd_base_next;
        req_reg        <= req_next;
        res_slot_reg   <= res_slot_next;
        res_found_reg  <= res_found_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= TOT_W'(TOTAL))
        else $error("free count above slot total");

    a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SCAN))
        else $error("pending word read outside a scan");

    a_found_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.found) |-> (out_data_reg.free_total != '0))
        else $error("free slot reported while free count is zero");

    a_no_xfer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("request transfer during clearing pass");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: bitmap free-slot allocator
// Sends find, occupy and release requests over the valid/ready request
// channel. Each transfer is run through a bit-level model of the occupancy
// map and the free count, and every result is compared field by field with
// the oldest prediction. The lowest words of the map are filled once so that
// finds scan deep, and long finds are spread through the fill.
// ----------------------------------------------------------------------------
module testbench;
    import bfsa_pkg::*;

    localparam int         MAP_WORDS    = 128;
    localparam int         WORD_BITS    = 32;
    localparam int         SLOTS        = MAP_WORDS * WORD_BITS;
    localparam int         FILL_SLOTS   = 256;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 200;
    localparam int         CALM_TAIL    = 60;
    localparam int         LONG_HOLD    = 400;
    localparam int         HOLD_AT      = 40;
    localparam int         END_CYCLES   = MAP_WORDS + 12;

    typedef struct packed {
        in_t  data;
        logic drain;
    } req_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // model state of the block
    logic [SLOTS-1:0]   slot_map = '0;
    logic [TOTAL_W-1:0] free_now = TOTAL_W'(SLOTS);

    // stimulus-side view of the map, used to shape allocation sequences
    bit [SLOTS-1:0] plan_map = '0;

    req_t req_queue[$];
    out_t expected_results[$];
    req_t next_req;
    out_t want;

    int sent_count = 0;
    int done_count = 0;
    int err_count  = 0;
    int gap_cnt    = 0;
    int stall_cnt  = 0;
    int hold_cnt   = 0;
    bit hold_done  = 1'b0;
    bit calm       = 1'b0;
    int total_items;

    bitmap_free_slot_allocator #(
        .MAP_WORDS(MAP_WORDS),
        .WORD_BITS(WORD_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #5 clk = ~clk;

    function automatic out_t allocator_predict(in_t req);
        out_t res;
        int   i;
        res = '0;
        case (req.op)
            OP_FIND:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!res.found && !slot_map[i])
                    begin
                        res.found     = 1'b1;
                        res.free_slot = i[SLOT_W-1:0];
                    end
                end
            end
            OP_OCCUPY:
            begin
                if (!slot_map[req.slot_index])
                begin
                    slot_map[req.slot_index] = 1'b1;
                    free_now = free_now - 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (slot_map[req.slot_index])
                begin
                    slot_map[req.slot_index] = 1'b0;
                    free_now = free_now + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.free_total = free_now;
        return res;
    endfunction

    task automatic queue_request(input logic [1:0] op, input int slot, input bit drain);
        req_t r;
        r.data.op         = op;
        r.data.slot_index = slot[SLOT_W-1:0];
        r.drain           = drain;
        req_queue.push_back(r);
        if (op == OP_OCCUPY)
            plan_map[slot] = 1'b1;
        else if (op == OP_RELEASE)
            plan_map[slot] = 1'b0;
    endtask

    function automatic bit plan_lowest_free(output int slot);
        int i;
        slot = 0;
        for (i = 0; i < SLOTS; i++)
        begin
            if (!plan_map[i])
            begin
                slot = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            gap_cnt    <= 0;
            sent_count <= 0;
            calm       <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(allocator_predict(in_data));
                sent_count <= sent_count + 1;
            end
            calm <= (req_queue.size() <= CALM_TAIL);
            // hold the payload until the transfer happens
            if (!in_valid || in_ready)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt  <= gap_cnt - 1;
                    in_valid <= 1'b0;
                end
                else if (req_queue.size() > 0 && (!req_queue[0].drain ||
                         (sent_count == done_count && !(in_valid && in_ready))))
                begin
                    next_req = req_queue.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= next_req.data;
                    if (!calm && $urandom_range(0, 4) == 0)
                        gap_cnt <= $urandom_range(1, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_cnt  <= 0;
            hold_cnt   <= 0;
            hold_done  <= 1'b0;
            done_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (done_count >= sent_count)
                begin
                    $error("unexpected result: free_slot %0d found %0d free_total %0d",
                           out_data.free_slot, out_data.found, out_data.free_total);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    done_count <= done_count + 1;
                    if (out_data.free_slot !== want.free_slot)
                    begin
                        $error("free_slot: expected %0d, got %0d",
                               want.free_slot, out_data.free_slot);
                        err_count++;
                    end
                    if (out_data.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, out_data.found);
                        err_count++;
                    end
                    if (out_data.free_total !== want.free_total)
                    begin
                        $error("free_total: expected %0d, got %0d",
                               want.free_total, out_data.free_total);
                        err_count++;
                    end
                end
            end
            // one long hold so the request side backs up
            if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && done_count == HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_cnt  <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_cnt <= $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int i;
        int slot;
        int useful;
        int pick;

        // corner requests on an empty map
        queue_request(OP_FIND, SLOTS - 1, 1'b0);
        queue_request(OP_OCCUPY, 0, 1'b0);
        queue_request(OP_FIND, 0, 1'b0);
        queue_request(OP_OCCUPY, 0, 1'b0);
        queue_request(OP_RELEASE, SLOTS - 1, 1'b0);
        queue_request(OP_OCCUPY, SLOTS - 1, 1'b0);
        queue_request(OP_UNUSED, SLOTS - 1, 1'b0);
        queue_request(OP_FIND, 1234, 1'b0);
        queue_request(OP_OCCUPY, 31, 1'b0);
        queue_request(OP_OCCUPY, 32, 1'b0);
        queue_request(OP_RELEASE, 0, 1'b0);
        queue_request(OP_FIND, 0, 1'b0);
        queue_request(OP_RELEASE, SLOTS - 1, 1'b0);
        queue_request(OP_UNUSED, 0, 1'b0);

        // fill the lowest words in scrambled order;
        // the first fill request waits for every result so far
        for (i = 0; i < FILL_SLOTS; i++)
        begin
            slot = (i * 37) % FILL_SLOTS;
            queue_request(OP_OCCUPY, slot, i == 0);
            if (i % 32 == 31)
                queue_request(OP_FIND, $urandom_range(0, SLOTS - 1), 1'b0);
        end
        queue_request(OP_FIND, 0, 1'b0);
        queue_request(OP_OCCUPY, SLOTS - 1, 1'b0);
        queue_request(OP_FIND, SLOTS - 1, 1'b0);
        queue_request(OP_OCCUPY, 100, 1'b0);
        queue_request(OP_UNUSED, 2730, 1'b0);

        // open holes, mostly in the filled words
        for (i = 0; i < 40; i++)
        begin
            if (i < 30)
                queue_request(OP_RELEASE, $urandom_range(0, FILL_SLOTS - 1), 1'b0);
            else
                queue_request(OP_RELEASE, $urandom_range(0, SLOTS - 1), 1'b0);
        end

        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // allocate: find, then occupy the slot it reports
                queue_request(OP_FIND, $urandom_range(0, SLOTS - 1),
                              $urandom_range(0, 49) == 0);
                useful++;
                if (plan_lowest_free(slot))
                begin
                    queue_request(OP_OCCUPY, slot, 1'b0);
                    useful++;
                end
            end
            else if (pick < 65)
            begin
                if (plan_lowest_free(slot))
                    queue_request(OP_RELEASE, $urandom_range(0, slot + 64) % SLOTS, 1'b0);
                else
                    queue_request(OP_RELEASE, $urandom_range(0, SLOTS - 1), 1'b0);
                useful++;
            end
            else if (pick < 75)
            begin
                queue_request(OP_OCCUPY, $urandom_range(0, SLOTS - 1), 1'b0);
                useful++;
            end
            else if (pick < 85)
            begin
                queue_request(OP_RELEASE, $urandom_range(0, SLOTS - 1), 1'b0);
                useful++;
            end
            else if (pick < 95)
            begin
                queue_request(OP_FIND, $urandom_range(0, SLOTS - 1), 1'b0);
                useful++;
            end
            else
            begin
                queue_request(OP_UNUSED, $urandom_range(0, SLOTS - 1), 1'b0);
            end
        end
        total_items = req_queue.size();

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_count == total_items);
        wait (done_count == sent_count);
        repeat (END_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== bitmap_free_slot_allocator.f =====
design/bfsa_pkg.sv
design/bitmap_free_slot_allocator.sv
test/testbench.sv
